// ===== rtl/woig_pkg.sv =====
package woig_pkg;

  // Field widths of the channels and registers
  localparam int MODE_W     = 2;
  localparam int FRAMES_W   = 8;
  localparam int ROWS_W     = 10;
  localparam int COLS_W     = 10;
  localparam int IDX_W      = 31;
  localparam int MERGE_W    = 4;
  localparam int WINPIX_W   = 11;
  localparam int PATCH_W    = 7;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Shared divider operand widths
  localparam int DVD_W = 11;
  localparam int DVS_W = 7;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_PIXELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_PIXELS  = 2'd2;

  // Configuration reset values
  localparam logic [MERGE_W-1:0]  MERGE_RESET  = 4'd2;
  localparam logic [WINPIX_W-1:0] WINPIX_RESET = 11'd112;
  localparam logic [PATCH_W-1:0]  PATCH_RESET  = 7'd14;

  // Saturation value of 31-bit sums
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADVANCE,
    OP_CLEAR
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_ROWS,
    ST_LD_COLS,
    ST_LD_WIN,
    ST_LD_SPAN,
    ST_LD_AREA,
    ST_LD_TOK,
    ST_ADV_MUL,
    ST_ADV_SUM,
    ST_ADV_FIN
  } back_state_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [FRAMES_W-1:0] grid_frames;
    logic [ROWS_W-1:0]   grid_rows;
    logic [COLS_W-1:0]   grid_cols;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] token_index;
    logic             window_last;
    logic [IDX_W-1:0] cumulative_length;
    logic             grid_last;
    logic             overflow;
  } out_item_t;

  typedef struct packed {
    op_e                 op;
    logic [FRAMES_W-1:0] grid_frames;
    logic [ROWS_W-1:0]   grid_rows;
    logic [COLS_W-1:0]   grid_cols;
  } cmd_t;

  typedef struct packed {
    logic [MERGE_W-1:0]  merge_factor;
    logic [WINPIX_W-1:0] window_pixels;
    logic [PATCH_W-1:0]  patch_pixels;
  } cfg_t;

endpackage

// ===== rtl/window_order_index_generator.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid_i/in_ready_o | in_data_i: mode, grid_frames/rows/cols
// out      | out_valid_o/out_ready_i | out_data_o: token_index .. overflow
// cfg      | cfg_we_i             | cfg_index_i, cfg_data_i
//
// An advance, once at the queue head, runs through pick-up, two product
// stages (frame and row offsets, window length) and the saturating commit.
// A load runs the shared restoring divider through four 11-step divisions;
// a clear or an advance with no grid is retired straight from idle.
// Reset is asynchronous and clears all control state; no clearing pass.
// A two-beat queue keeps input flowing while the back end works; the result
// register holds a beat until taken, and the commit waits for it to drain.
module window_order_index_generator #(
  parameter int MAX_GRID   = 1024,
  parameter int MAX_FRAMES = 256,
  parameter int MAX_SPAN   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [woig_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [woig_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  woig_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output woig_pkg::out_item_t             out_data_o
);
  import woig_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.merge_factor  <= MERGE_RESET;
      cfg_q.window_pixels <= WINPIX_RESET;
      cfg_q.patch_pixels  <= PATCH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MERGE_SIZE:    cfg_q.merge_factor  <= cfg_data_i[MERGE_W-1:0];
        CFG_WINDOW_PIXELS: cfg_q.window_pixels <= cfg_data_i[WINPIX_W-1:0];
        CFG_PATCH_PIXELS:  cfg_q.patch_pixels  <= cfg_data_i[PATCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  woig_front #(
    .MAX_GRID   (MAX_GRID),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  woig_back #(
    .MAX_GRID   (MAX_GRID),
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_SPAN   (MAX_SPAN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/woig_div.sv =====
module woig_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [woig_pkg::DVD_W-1:0] dividend_i,
  input  logic [woig_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [woig_pkg::DVD_W-1:0] quotient_o
);
  import woig_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVD_W-1:0] quo_q;

  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W-1:0] rem_next;

  // One restoring step: shift in the next dividend bit and try the subtract
  always_comb begin
    trial    = {rem_q, quo_q[DVD_W-1]};
    fits     = trial >= {1'b0, dvs_q};
    rem_next = fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
  end

  // Sequence control: one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/woig_front.sv =====
module woig_front #(
  parameter int MAX_GRID   = 1024,
  parameter int MAX_FRAMES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  woig_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  output woig_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);
  import woig_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  cmd_t cmd_in;
  logic push;
  logic pop;

  // Classify the beat and clamp the grid sizes
  always_comb begin
    cmd_in.grid_frames = in_data_i.grid_frames;
    cmd_in.grid_rows   = in_data_i.grid_rows;
    cmd_in.grid_cols   = in_data_i.grid_cols;
    case (in_data_i.mode)
      MODE_LOAD:    cmd_in.op = OP_LOAD;
      MODE_ADVANCE: cmd_in.op = OP_ADVANCE;
      MODE_CLEAR:   cmd_in.op = OP_CLEAR;
      default:      cmd_in.op = OP_NONE;
    endcase
    if (int'(in_data_i.grid_frames) > MAX_FRAMES - 1) begin
      cmd_in.grid_frames = FRAMES_W'(MAX_FRAMES - 1);
    end
    if (int'(in_data_i.grid_rows) > MAX_GRID - 1) begin
      cmd_in.grid_rows = ROWS_W'(MAX_GRID - 1);
    end
    if (int'(in_data_i.grid_cols) > MAX_GRID - 1) begin
      cmd_in.grid_cols = COLS_W'(MAX_GRID - 1);
    end
  end

  // Drop beats that carry no work; queue the rest
  assign in_ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign push       = in_valid_i && in_ready_o && (cmd_in.op != OP_NONE);
  assign pop        = cmd_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = q_mem[rd_ptr_q];

endmodule

// ===== rtl/woig_back.sv =====
module woig_back #(
  parameter int MAX_GRID   = 1024,
  parameter int MAX_FRAMES = 256,
  parameter int MAX_SPAN   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  woig_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  woig_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output woig_pkg::out_item_t out_data_o
);
  import woig_pkg::*;

  localparam int GRID_BITS = $clog2(MAX_GRID);
  localparam int ROW_W     = (GRID_BITS < ROWS_W) ? GRID_BITS : ROWS_W;
  localparam int FRM_BITS  = $clog2(MAX_FRAMES);
  localparam int FRM_W     = (FRM_BITS < 1) ? 1 : ((FRM_BITS < FRAMES_W) ? FRM_BITS : FRAMES_W);
  localparam int SPW       = $clog2(MAX_SPAN + 1);
  localparam int CW        = ((ROW_W > SPW) ? ROW_W : SPW) + 1;
  localparam int AREA_W    = 2 * ROW_W;
  localparam int TOK_W     = FRM_W + AREA_W;
  localparam int VV_W      = 2 * SPW;
  localparam int MM_W      = 2 * MERGE_W;
  localparam int LEN_W     = VV_W + MM_W;
  localparam int SUM_W     = IDX_W + 1;

  back_state_e state_q, state_d;

  // Control state
  logic [IDX_W-1:0] base_q, base_d;
  logic [IDX_W-1:0] total_q, total_d;
  logic             ovf_q, ovf_d;
  logic             active_q, active_d;
  logic [ROW_W-1:0] mr_q, mr_d;
  logic [ROW_W-1:0] mc_q, mc_d;
  logic [FRM_W-1:0] frames_q, frames_d;
  logic [SPW-1:0]   span_q, span_d;
  logic [FRM_W-1:0] frame_q, frame_d;
  logic [ROW_W-1:0] r0_q, r0_d;
  logic [ROW_W-1:0] c0_q, c0_d;
  logic [SPW-1:0]   irow_q, irow_d;
  logic [SPW-1:0]   icol_q, icol_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  // Datapath registers
  logic [AREA_W-1:0] area_q;
  logic [TOK_W-1:0]  tokens_q;
  logic [TOK_W-1:0]  fa_q;
  logic [AREA_W-1:0] rc_q;
  logic [ROW_W-1:0]  gw_q;
  logic [SPW-1:0]    vh_q, vw_q;
  logic [VV_W-1:0]   vv_q;
  logic [MM_W-1:0]   mm_q;
  logic              wlast_q, lastwr_q, lastwc_q, glast_q;
  logic [TOK_W-1:0]  local_q;
  logic [LEN_W-1:0]  lenp_q;

  // Divider hookup
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;

  logic [MERGE_W-1:0] eff_merge;
  logic [PATCH_W-1:0] eff_patch;
  logic [FRM_W-1:0]   frames_trim;
  logic [SPW-1:0]     span_val;

  // Window geometry of the current position
  logic [CW-1:0]    span_c, mr_c, mc_c, r0_c, c0_c;
  logic [CW-1:0]    row_room, col_room;
  logic [SPW-1:0]   vh_c, vw_c;
  logic [ROW_W-1:0] gh_c, gw_c;
  logic             wlast_c, lastwr_c, lastwc_c, glast_c;

  // Commit sums
  logic [SUM_W-1:0] idx_sum, len_sum, tok_sum;
  logic [IDX_W-1:0] idx_val, len_val, tok_val;
  logic             icol_wrap, irow_wrap;

  woig_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Zero divisors act as one
  assign eff_merge   = (cfg_i.merge_factor == '0) ? MERGE_W'(1) : cfg_i.merge_factor;
  assign eff_patch   = (cfg_i.patch_pixels == '0) ? PATCH_W'(1) : cfg_i.patch_pixels;
  assign frames_trim = FRM_W'(cmd_i.grid_frames);

  // Clamp the span to one and MAX_SPAN
  always_comb begin
    if (div_quot == '0) begin
      span_val = SPW'(1);
    end else if (int'(div_quot) > MAX_SPAN) begin
      span_val = SPW'(MAX_SPAN);
    end else begin
      span_val = SPW'(div_quot);
    end
  end

  // Valid extent of the current window and the last-of flags
  always_comb begin
    span_c   = CW'(span_q);
    mr_c     = CW'(mr_q);
    mc_c     = CW'(mc_q);
    r0_c     = CW'(r0_q);
    c0_c     = CW'(c0_q);
    row_room = mr_c - r0_c;
    col_room = mc_c - c0_c;
    vh_c     = (row_room < span_c) ? SPW'(row_room) : span_q;
    vw_c     = (col_room < span_c) ? SPW'(col_room) : span_q;
    gh_c     = ROW_W'(r0_c + CW'(irow_q));
    gw_c     = ROW_W'(c0_c + CW'(icol_q));
    wlast_c  = ({1'b0, irow_q} + 1'b1 >= {1'b0, vh_c})
            && ({1'b0, icol_q} + 1'b1 >= {1'b0, vw_c});
    lastwr_c = r0_c + span_c >= mr_c;
    lastwc_c = c0_c + span_c >= mc_c;
    glast_c  = wlast_c && lastwr_c && lastwc_c
            && ({1'b0, frame_q} + 1'b1 >= {1'b0, frames_q});
  end

  // Saturating 31-bit sums for the commit step
  always_comb begin
    idx_sum = {1'b0, base_q} + SUM_W'(local_q);
    len_sum = {1'b0, total_q} + SUM_W'(lenp_q);
    tok_sum = {1'b0, base_q} + SUM_W'(tokens_q);
    idx_val = idx_sum[IDX_W] ? IDX_MAX : idx_sum[IDX_W-1:0];
    len_val = len_sum[IDX_W] ? IDX_MAX : len_sum[IDX_W-1:0];
    tok_val = tok_sum[IDX_W] ? IDX_MAX : tok_sum[IDX_W-1:0];
    icol_wrap = {1'b0, icol_q} + 1'b1 >= {1'b0, vw_q};
    irow_wrap = {1'b0, irow_q} + 1'b1 >= {1'b0, vh_q};
  end

  // Sequencer: next state, control updates and result register
  always_comb begin
    state_d      = state_q;
    cmd_pop_o    = 1'b0;
    div_start    = 1'b0;
    div_dividend = DVD_W'(cmd_i.grid_rows);
    div_divisor  = DVS_W'(eff_merge);
    base_d       = base_q;
    total_d      = total_q;
    ovf_d        = ovf_q;
    active_d     = active_q;
    mr_d         = mr_q;
    mc_d         = mc_q;
    frames_d     = frames_q;
    span_d       = span_q;
    frame_d      = frame_q;
    r0_d         = r0_q;
    c0_d         = c0_q;
    irow_d       = irow_q;
    icol_d       = icol_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_LOAD: begin
              div_start = 1'b1;
              state_d   = ST_LD_ROWS;
            end
            OP_ADVANCE: begin
              if (active_q) begin
                state_d = ST_ADV_MUL;
              end else begin
                cmd_pop_o = 1'b1;
              end
            end
            OP_CLEAR: begin
              base_d    = '0;
              total_d   = '0;
              ovf_d     = 1'b0;
              cmd_pop_o = 1'b1;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_LD_ROWS: begin
        if (div_done) begin
          mr_d         = ROW_W'(div_quot);
          div_start    = 1'b1;
          div_dividend = DVD_W'(cmd_i.grid_cols);
          state_d      = ST_LD_COLS;
        end
      end
      ST_LD_COLS: begin
        if (div_done) begin
          mc_d         = ROW_W'(div_quot);
          div_start    = 1'b1;
          div_dividend = DVD_W'(cfg_i.window_pixels);
          state_d      = ST_LD_WIN;
        end
      end
      ST_LD_WIN: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_quot;
          div_divisor  = DVS_W'(eff_patch);
          state_d      = ST_LD_SPAN;
        end
      end
      ST_LD_SPAN: begin
        if (div_done) begin
          span_d  = span_val;
          state_d = ST_LD_AREA;
        end
      end
      ST_LD_AREA: begin
        state_d = ST_LD_TOK;
      end
      ST_LD_TOK: begin
        frames_d  = frames_trim;
        frame_d   = '0;
        r0_d      = '0;
        c0_d      = '0;
        irow_d    = '0;
        icol_d    = '0;
        active_d  = (cmd_i.grid_frames != '0) && (mr_q != '0) && (mc_q != '0);
        cmd_pop_o = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_ADV_MUL: begin
        state_d = ST_ADV_SUM;
      end
      ST_ADV_SUM: begin
        state_d = ST_ADV_FIN;
      end
      ST_ADV_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          ovf_d = ovf_q | idx_sum[IDX_W] | (wlast_q & len_sum[IDX_W])
                | (glast_q & tok_sum[IDX_W]);
          if (wlast_q) begin
            total_d = len_val;
          end
          // Step column, row, window and frame
          icol_d = icol_q + 1'b1;
          if (icol_wrap) begin
            icol_d = '0;
            irow_d = irow_q + 1'b1;
            if (irow_wrap) begin
              irow_d = '0;
              c0_d   = ROW_W'(c0_c + span_c);
              if (lastwc_q) begin
                c0_d = '0;
                r0_d = ROW_W'(r0_c + span_c);
                if (lastwr_q) begin
                  r0_d    = '0;
                  frame_d = frame_q + 1'b1;
                end
              end
            end
          end
          if (glast_q) begin
            base_d   = tok_val;
            active_d = 1'b0;
            frame_d  = '0;
          end
          out_valid_d                 = 1'b1;
          out_d.token_index           = idx_val;
          out_d.window_last           = wlast_q;
          out_d.cumulative_length     = wlast_q ? len_val : '0;
          out_d.grid_last             = glast_q;
          out_d.overflow              = ovf_d;
          cmd_pop_o                   = 1'b1;
          state_d                     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      active_q    <= 1'b0;
      mr_q        <= '0;
      mc_q        <= '0;
      frames_q    <= '0;
      span_q      <= SPW'(1);
      frame_q     <= '0;
      r0_q        <= '0;
      c0_q        <= '0;
      irow_q      <= '0;
      icol_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      active_q    <= active_d;
      mr_q        <= mr_d;
      mc_q        <= mc_d;
      frames_q    <= frames_d;
      span_q      <= span_d;
      frame_q     <= frame_d;
      r0_q        <= r0_d;
      c0_q        <= c0_d;
      irow_q      <= irow_d;
      icol_q      <= icol_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Products and partial sums of the load and advance steps
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    case (state_q)
      ST_LD_AREA: begin
        area_q <= AREA_W'(mr_q) * AREA_W'(mc_q);
      end
      ST_LD_TOK: begin
        tokens_q <= TOK_W'(frames_trim) * TOK_W'(area_q);
      end
      ST_ADV_MUL: begin
        fa_q     <= TOK_W'(frame_q) * TOK_W'(area_q);
        rc_q     <= AREA_W'(gh_c) * AREA_W'(mc_q);
        gw_q     <= gw_c;
        vh_q     <= vh_c;
        vw_q     <= vw_c;
        vv_q     <= VV_W'(vh_c) * VV_W'(vw_c);
        mm_q     <= MM_W'(eff_merge) * MM_W'(eff_merge);
        wlast_q  <= wlast_c;
        lastwr_q <= lastwr_c;
        lastwc_q <= lastwc_c;
        glast_q  <= glast_c;
      end
      ST_ADV_SUM: begin
        local_q <= fa_q + TOK_W'(rc_q) + TOK_W'(gw_q);
        lenp_q  <= LEN_W'(vv_q) * LEN_W'(mm_q);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/token_order_checker.sv =====
`timescale 1ns / 100ps

module token_order_checker #(
  parameter int MAX_GRID   = 1024,
  parameter int MAX_FRAMES = 256,
  parameter int MAX_SPAN   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [woig_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [woig_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  woig_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  woig_pkg::out_item_t             out_data_o,
  output int                              fail_count_o,
  output int                              pending_o
);
  import woig_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam longint unsigned LIMIT31 = 64'h7FFF_FFFF;

  // Register copies, updated on every write
  logic [MERGE_W-1:0]  merge_q;
  logic [WINPIX_W-1:0] winpix_q;
  logic [PATCH_W-1:0]  patch_q;

  // Scan state of the grid being walked
  logic [IDX_W-1:0]    base_idx;
  logic [IDX_W-1:0]    len_total;
  logic [ROWS_W-1:0]   m_rows;
  logic [COLS_W-1:0]   m_cols;
  logic [FRAMES_W-1:0] n_frames;
  logic [FRAMES_W-1:0] frame_cnt;
  logic [SPAN_W-1:0]   span;
  logic [ROWS_W-1:0]   win_r;
  logic [COLS_W-1:0]   win_c;
  logic [SPAN_W-1:0]   in_r;
  logic [SPAN_W-1:0]   in_c;
  logic                grid_on;
  logic                ovf_sticky;

  out_item_t expected_tokens[$];
  int        mismatches;

  function automatic longint unsigned merge_eff();
    return (merge_q == '0) ? 64'd1 : 64'(merge_q);
  endfunction

  // Saturate a sum to 31 bits and note the overflow
  function automatic logic [IDX_W-1:0] clamp31(input longint unsigned v);
    if (v > LIMIT31) begin
      ovf_sticky = 1'b1;
      return IDX_MAX;
    end
    return v[IDX_W-1:0];
  endfunction

  // Latch a grid: merge the sizes, derive the window span, restart the scan
  function automatic void latch_grid(input in_item_t beat);
    longint unsigned m, p, f, r, c, s;
    m = merge_eff();
    p = (patch_q == '0) ? 64'd1 : 64'(patch_q);
    f = beat.grid_frames;
    r = beat.grid_rows;
    c = beat.grid_cols;
    if (f > MAX_FRAMES - 1) f = MAX_FRAMES - 1;
    if (r > MAX_GRID - 1) r = MAX_GRID - 1;
    if (c > MAX_GRID - 1) c = MAX_GRID - 1;
    s = 64'(winpix_q) / m / p;
    if (s == 0) s = 1;
    if (s > MAX_SPAN) s = MAX_SPAN;
    span      = s[SPAN_W-1:0];
    m_rows    = ROWS_W'(r / m);
    m_cols    = COLS_W'(c / m);
    n_frames  = FRAMES_W'(f);
    frame_cnt = '0;
    win_r     = '0;
    win_c     = '0;
    in_r      = '0;
    in_c      = '0;
    grid_on   = (f != 0) && (m_rows != '0) && (m_cols != '0);
  endfunction

  // Emit the next window-ordered token and step the scan
  function automatic void next_token(output out_item_t tok);
    longint unsigned s, r0, c0, vh, vw, offs, mm;
    logic wl, lwr, lwc, gl;
    logic [IDX_W-1:0] cum;
    s  = span;
    r0 = 64'(win_r) * s;
    c0 = 64'(win_c) * s;
    vh = (64'(m_rows) - r0 < s) ? 64'(m_rows) - r0 : s;
    vw = (64'(m_cols) - c0 < s) ? 64'(m_cols) - c0 : s;
    offs = 64'(frame_cnt) * m_rows * m_cols + (r0 + in_r) * m_cols + c0 + in_c;
    tok.token_index = clamp31(64'(base_idx) + offs);

    wl  = (64'(in_r) + 1 >= vh) && (64'(in_c) + 1 >= vw);
    lwr = (r0 + s >= m_rows);
    lwc = (c0 + s >= m_cols);
    gl  = wl && lwr && lwc && (64'(frame_cnt) + 1 >= n_frames);

    // Close the window: add its padded-free length times merge squared
    cum = '0;
    if (wl) begin
      mm = merge_eff();
      len_total = clamp31(64'(len_total) + vh * vw * mm * mm);
      cum = len_total;
    end

    // Advance column, row in window, window column, window row, frame
    in_c = in_c + 1'b1;
    if (in_c >= vw) begin
      in_c = '0;
      in_r = in_r + 1'b1;
      if (in_r >= vh) begin
        in_r  = '0;
        win_c = win_c + 1'b1;
        if (lwc) begin
          win_c = '0;
          win_r = win_r + 1'b1;
          if (lwr) begin
            win_r     = '0;
            frame_cnt = frame_cnt + 1'b1;
          end
        end
      end
    end

    // Retire the grid into the base
    if (gl) begin
      base_idx  = clamp31(64'(base_idx) + 64'(n_frames) * m_rows * m_cols);
      grid_on   = 1'b0;
      frame_cnt = '0;
    end

    tok.window_last       = wl;
    tok.cumulative_length = cum;
    tok.grid_last         = gl;
    tok.overflow          = ovf_sticky;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_p
    out_item_t want;
    out_item_t got;
    out_item_t tok;
    if (!rst_ni) begin
      merge_q    = MERGE_RESET;
      winpix_q   = WINPIX_RESET;
      patch_q    = PATCH_RESET;
      base_idx   = '0;
      len_total  = '0;
      m_rows     = '0;
      m_cols     = '0;
      n_frames   = '0;
      frame_cnt  = '0;
      span       = SPAN_W'(1);
      win_r      = '0;
      win_c      = '0;
      in_r       = '0;
      in_c       = '0;
      grid_on    = 1'b0;
      ovf_sticky = 1'b0;
      expected_tokens.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Check a returned beat against the oldest prediction
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (expected_tokens.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t unexpected token beat: idx %0d wlast %0b cum %0d glast %0b ovf %0b",
                     $time, got.token_index, got.window_last, got.cumulative_length,
                     got.grid_last, got.overflow);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (got.token_index !== want.token_index ||
              got.window_last !== want.window_last ||
              got.cumulative_length !== want.cumulative_length ||
              got.grid_last !== want.grid_last ||
              got.overflow !== want.overflow) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t mismatch expected: idx %0d wlast %0b cum %0d glast %0b ovf %0b",
                       $time, want.token_index, want.window_last, want.cumulative_length,
                       want.grid_last, want.overflow);
              $display("%0t mismatch actual:   idx %0d wlast %0b cum %0d glast %0b ovf %0b",
                       $time, got.token_index, got.window_last, got.cumulative_length,
                       got.grid_last, got.overflow);
            end
            mismatches++;
          end
        end
      end

      // Track register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MERGE_SIZE:    merge_q  = cfg_data_i[MERGE_W-1:0];
          CFG_WINDOW_PIXELS: winpix_q = cfg_data_i[WINPIX_W-1:0];
          CFG_PATCH_PIXELS:  patch_q  = cfg_data_i[PATCH_W-1:0];
          default: ;
        endcase
      end

      // Predict from each accepted input beat
      if (in_valid_i && in_ready_o) begin
        case (in_data_i.mode)
          MODE_LOAD: latch_grid(in_data_i);
          MODE_ADVANCE: begin
            if (grid_on) begin
              next_token(tok);
              expected_tokens.insert(expected_tokens.size(), tok);
            end
          end
          MODE_CLEAR: begin
            base_idx   = '0;
            len_total  = '0;
            ovf_sticky = 1'b0;
          end
          default: ;
        endcase
      end

      fail_count_o <= mismatches;
      pending_o    <= expected_tokens.size();
    end
  end

endmodule

// ===== tb/tb_window_order_index_generator.sv =====
`timescale 1ns / 100ps

module tb_window_order_index_generator;
  import woig_pkg::*;

  localparam int MAX_GRID   = 1024;
  localparam int MAX_FRAMES = 256;
  localparam int MAX_SPAN   = 16;

  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int SETTLE_CYCLES = 200;
  localparam int ITEM_GOAL     = 1400;
  localparam int FRAMES_TOP    = (1 << FRAMES_W) - 1;
  localparam int ROWS_TOP      = (1 << ROWS_W) - 1;
  localparam int COLS_TOP      = (1 << COLS_W) - 1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;

  int          fail_count;
  int          pending;
  int          gap_rate;
  int          stall_rate;
  int unsigned items_sent;
  int unsigned cur_merge;

  window_order_index_generator #(
    .MAX_GRID  (MAX_GRID),
    .MAX_FRAMES(MAX_FRAMES),
    .MAX_SPAN  (MAX_SPAN)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  token_order_checker #(
    .MAX_GRID  (MAX_GRID),
    .MAX_FRAMES(MAX_FRAMES),
    .MAX_SPAN  (MAX_SPAN)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side in random bursts
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_rate != 0 && $urandom_range(1, 100) <= stall_rate) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("FAIL window_order_index_generator");
    $finish;
  end

  // Offer one beat, hold it until accepted, then maybe idle
  task automatic send_beat(input logic [MODE_W-1:0] mode, input int unsigned frames,
                           input int unsigned rows, input int unsigned cols);
    in_item_t beat;
    beat.mode        = mode;
    beat.grid_frames = frames[FRAMES_W-1:0];
    beat.grid_rows   = rows[ROWS_W-1:0];
    beat.grid_cols   = cols[COLS_W-1:0];
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (mode != MODE_IGNORED) items_sent++;
    if (gap_rate != 0 && $urandom_range(1, 100) <= gap_rate) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Hold off input until every token is back and the block has gone quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned merge, input int unsigned winpix,
                           input int unsigned patch);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MERGE_SIZE;
    cfg_data_i  <= CFG_DATA_W'(merge);
    @(posedge clk_i);
    cfg_index_i <= CFG_WINDOW_PIXELS;
    cfg_data_i  <= CFG_DATA_W'(winpix);
    @(posedge clk_i);
    cfg_index_i <= CFG_PATCH_PIXELS;
    cfg_data_i  <= CFG_DATA_W'(patch);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_merge = merge & 4'hF;
  endtask

  task automatic send_advance();
    send_beat(MODE_ADVANCE, $urandom_range(0, FRAMES_TOP), $urandom_range(0, ROWS_TOP),
              $urandom_range(0, COLS_TOP));
  endtask

  // Mostly whole grid scans, some cut short, some noise and clears
  task automatic run_phase(input int unsigned goal);
    int unsigned start, m, mr, mc, fr, tokens, cut, pick;
    start = items_sent;
    while (items_sent - start < goal) begin
      pick = $urandom_range(0, 9);
      if (pick <= 7) begin
        m  = (cur_merge == 0) ? 1 : cur_merge;
        mr = $urandom_range(1, 8);
        mc = $urandom_range(1, 8);
        fr = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(1, 2);
        tokens = fr * mr * mc;
        cut = (pick == 7) ? $urandom_range(0, tokens - 1) : tokens;
        send_beat(MODE_LOAD, fr, mr * m + $urandom_range(0, m - 1),
                  mc * m + $urandom_range(0, m - 1));
        for (int k = 0; k < cut; k++) begin
          if ($urandom_range(0, 49) == 0)
            send_beat(MODE_CLEAR, $urandom_range(0, FRAMES_TOP), 0, 0);
          send_advance();
        end
        if ($urandom_range(0, 3) == 0) send_advance();
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6))
          send_beat(MODE_W'($urandom_range(MODE_LOAD, MODE_IGNORED)),
                    $urandom_range(0, FRAMES_TOP),
                    $urandom_range(0, ROWS_TOP), $urandom_range(0, COLS_TOP));
      end else begin
        send_beat(MODE_CLEAR, 0, $urandom_range(0, ROWS_TOP), $urandom_range(0, COLS_TOP));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    gap_rate    = 0;
    stall_rate  = 20;
    items_sent  = 0;
    cur_merge   = MERGE_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty grids, no grid, ignored code, partial windows, clear mid-scan
    send_beat(MODE_ADVANCE, 0, 0, 0);
    send_beat(MODE_IGNORED, FRAMES_TOP, ROWS_TOP, COLS_TOP);
    send_beat(MODE_LOAD, 0, 8, 8);
    send_beat(MODE_LOAD, 1, 1, 8);
    send_beat(MODE_ADVANCE, 0, 0, 0);
    // Two merged rows by five cols, span four: a four-column window then a one-column window
    send_beat(MODE_LOAD, 1, 4, 10);
    repeat (10) send_beat(MODE_ADVANCE, 0, 0, 0);
    send_beat(MODE_LOAD, FRAMES_TOP, ROWS_TOP, COLS_TOP);
    repeat (3) send_beat(MODE_ADVANCE, FRAMES_TOP, ROWS_TOP, COLS_TOP);
    send_beat(MODE_CLEAR, 0, 0, 0);
    send_beat(MODE_ADVANCE, 0, 0, 0);
    // Single merged token per frame, dropping the large grid
    send_beat(MODE_LOAD, 2, 3, 2);
    repeat (3) send_beat(MODE_ADVANCE, 0, 0, 0);

    // Random phases, each under its own register setting
    for (int ph = 0; items_sent < ITEM_GOAL - 150; ph++) begin
      drain_results();
      case (ph)
        0: configure(0, 2047, 127);
        1: configure(15, 0, 0);
        2: configure(1, 2047, 1);
        3: configure(8, 1024, 64);
        4: configure(1, 1, 1);
        5: configure(4, 2047, 0);
        default: begin
          if ($urandom_range(0, 2) == 0)
            configure($urandom_range(0, 15), $urandom_range(0, 2047), $urandom_range(0, 127));
          else
            configure($urandom_range(1, 4), $urandom_range(8, 512), $urandom_range(1, 16));
        end
      endcase
      if (ph % 4 == 3) begin
        gap_rate   = 0;
        stall_rate = 0;
      end else begin
        gap_rate   = $urandom_range(5, 30);
        stall_rate = $urandom_range(5, 30);
      end
      run_phase(110);
    end

    // Close at full rate with the reset setting
    drain_results();
    gap_rate   = 0;
    stall_rate = 0;
    configure(MERGE_RESET, WINPIX_RESET, PATCH_RESET);
    run_phase(120);

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS window_order_index_generator");
    end else begin
      $display("FAIL window_order_index_generator");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/woig_pkg.sv
rtl/woig_div.sv
rtl/woig_front.sv
rtl/woig_back.sv
rtl/window_order_index_generator.sv
tb/token_order_checker.sv
tb/tb_window_order_index_generator.sv
